/* sv/radix2_fft_frame_assert.svh */
// Assertion helpers for the file that checks this block.
`ifndef RADIX2_FFT_FRAME_ASSERT_SVH
`define RADIX2_FFT_FRAME_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define R2FFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define R2FFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/r2fft_pkg.sv */
package r2fft_pkg;

  localparam int DW = 24;

  typedef struct packed {
    logic signed [DW-1:0] im;
    logic signed [DW-1:0] re;
  } cplx_t;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } twiddle_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FFT,
    ST_UNLOAD
  } state_t;

  // round(32768*cos(2*pi*i/64)) for i = 0..16, +1.0 held as 32767
  function automatic logic signed [15:0] qcos(input logic [4:0] i);
    logic signed [15:0] v;
    unique case (i)
      5'd0:  v = 16'sd32767;
      5'd1:  v = 16'sd32610;
      5'd2:  v = 16'sd32138;
      5'd3:  v = 16'sd31357;
      5'd4:  v = 16'sd30274;
      5'd5:  v = 16'sd28899;
      5'd6:  v = 16'sd27246;
      5'd7:  v = 16'sd25330;
      5'd8:  v = 16'sd23170;
      5'd9:  v = 16'sd20788;
      5'd10: v = 16'sd18205;
      5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540;
      5'd13: v = 16'sd9512;
      5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // W^k on a 64-point circle, k in 0..31
  function automatic twiddle_t twiddle(input logic [4:0] k);
    twiddle_t w;
    logic signed [15:0] c;
    logic signed [15:0] s;
    if (k <= 5'd16) begin
      c = qcos(k);
      s = qcos(5'd16 - k);
    end else begin
      c = -qcos(5'd0 - k);
      s = qcos(k - 5'd16);
    end
    w.re = c;
    w.im = -s;
    return w;
  endfunction

endpackage

/* sv/r2fft_ram.sv */
module r2fft_ram #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        wa,
  input  r2fft_pkg::cplx_t     wd,
  input  logic [AW-1:0]        ra,
  output r2fft_pkg::cplx_t     rd
);

  r2fft_pkg::cplx_t mem [DEPTH];
  r2fft_pkg::cplx_t rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

/* sv/r2fft_bfly.sv */
module r2fft_bfly (
  input  logic                 clk,
  input  logic                 en_mul,
  input  logic                 en_add,
  input  r2fft_pkg::cplx_t     a_in,
  input  r2fft_pkg::cplx_t     b_in,
  input  r2fft_pkg::twiddle_t  tw,
  output r2fft_pkg::cplx_t     sum_o,
  output r2fft_pkg::cplx_t     diff_o
);

  logic signed [39:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  r2fft_pkg::cplx_t   a_d_r;
  r2fft_pkg::cplx_t   sum_r, diff_r;
  logic signed [41:0] s_re, s_im;
  logic signed [r2fft_pkg::DW-1:0] t_re, t_im;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p_rr_r <= b_in.re * tw.re;
      p_ii_r <= b_in.im * tw.im;
      p_ri_r <= b_in.re * tw.im;
      p_ir_r <= b_in.im * tw.re;
      a_d_r  <= a_in;
    end
  end

  // round half up, then floor shift by 15
  always_comb begin
    s_re = 42'(p_rr_r) - 42'(p_ii_r) + 42'sd16384;
    s_im = 42'(p_ri_r) + 42'(p_ir_r) + 42'sd16384;
    t_re = s_re[38:15];
    t_im = s_im[38:15];
  end

  always_ff @(posedge clk) begin
    if (en_add) begin
      sum_r.re  <= a_d_r.re + t_re;
      sum_r.im  <= a_d_r.im + t_im;
      diff_r.re <= a_d_r.re - t_re;
      diff_r.im <= a_d_r.im - t_im;
    end
  end

  assign sum_o  = sum_r;
  assign diff_o = diff_r;

endmodule

/* sv/radix2_fft_frame.sv */
// Forward radix-2 decimation-in-time FFT over a frame of POINTS complex samples (power of
// two, 2..64). Samples are taken one per beat and written straight to bit-reversed places
// of a single frame memory (one write and one registered read port). After the last sample
// the block stops taking input and runs log2(POINTS) passes in place with one butterfly
// unit; the memory's single read port makes each butterfly read a, then b, and each pass
// drains the butterfly pipeline before the next one reads. Bins then leave in natural
// order, tlast on the last one; the next bin is read only when the output is free or
// being taken. Twiddles are Q1.15, products rounded half up, sums unscaled; the 24-bit
// bins cannot overflow for 16-bit input. No clearing pass is needed after reset.
`include "radix2_fft_frame_assert.svh"

module radix2_fft_frame #(
  parameter int POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] sample_re, [31:16] sample_im
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [23:0] bin_re, [47:24] bin_im
  output logic        out_tlast   // last_bin
);

  localparam int AW = $clog2(POINTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(POINTS - 1);
  localparam logic [AW-1:0] LAST_BF  = AW'(POINTS / 2 - 1);
  localparam logic [2:0]    LAST_STG = 3'(AW - 1);

  typedef struct packed {
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [4:0]    k;
  } bf_addr_t;

  r2fft_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] lcnt_r, lcnt_nxt;
  logic [2:0]    stg_r, stg_nxt;
  logic [AW-1:0] bf_r, bf_nxt;
  logic          ph_r, ph_nxt;
  logic          done_r, done_nxt;
  logic [5:1]    v_r;
  logic          issue;
  bf_addr_t      ad1_r, ad2_r, ad3_r, ad4_r, cur_ad;
  r2fft_pkg::cplx_t a_hold_r;

  logic [AW-1:0] ucnt_r, ucnt_nxt;
  logic          pend_r, pend_nxt, pend_last_r;
  logic          out_valid_r, out_valid_nxt, out_last_r;
  r2fft_pkg::cplx_t out_data_r;
  logic          uissue;

  logic          we;
  logic [AW-1:0] wa, ra, lrev;
  r2fft_pkg::cplx_t wd, rd, sum, diff, samp;
  logic [AW-1:0] half, mask, aa;
  logic [5:0]    j6;

  assign in_tready = (state_r == r2fft_pkg::ST_LOAD);

  // bit-reversed load address
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      lrev[i] = lcnt_r[AW-1-i];
    end
  end

  assign samp.re = {{8{in_tdata[15]}}, in_tdata[15:0]};
  assign samp.im = {{8{in_tdata[31]}}, in_tdata[31:16]};

  // butterfly addresses for the current pass
  always_comb begin
    half     = AW'(1) << stg_r;
    mask     = half - AW'(1);
    aa       = ((bf_r & ~mask) << 1) | (bf_r & mask);
    j6       = 6'(bf_r & mask);
    cur_ad.a = aa;
    cur_ad.b = aa | half;
    cur_ad.k = 5'(j6 << (3'd5 - stg_r));
  end

  // control: load, butterfly issue, unload
  always_comb begin
    state_nxt     = state_r;
    lcnt_nxt      = lcnt_r;
    stg_nxt       = stg_r;
    bf_nxt        = bf_r;
    ph_nxt        = ph_r;
    done_nxt      = done_r;
    ucnt_nxt      = ucnt_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    issue         = 1'b0;
    uissue        = 1'b0;
    ra            = cur_ad.a;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_r) begin
      out_valid_nxt = 1'b1;
    end

    unique case (state_r)
      r2fft_pkg::ST_LOAD: begin
        if (in_tvalid) begin
          lcnt_nxt = lcnt_r + AW'(1);
          if (lcnt_r == LAST_IDX) begin
            lcnt_nxt  = '0;
            state_nxt = r2fft_pkg::ST_FFT;
            stg_nxt   = '0;
            bf_nxt    = '0;
            ph_nxt    = 1'b0;
            done_nxt  = 1'b0;
          end
        end
      end
      r2fft_pkg::ST_FFT: begin
        if (!done_r) begin
          // read a, then b, of one butterfly
          if (!ph_r) begin
            issue  = 1'b1;
            ph_nxt = 1'b1;
          end else begin
            ra     = cur_ad.b;
            ph_nxt = 1'b0;
            bf_nxt = bf_r + AW'(1);
            if (bf_r == LAST_BF) begin
              done_nxt = 1'b1;
            end
          end
        end else if (v_r == '0) begin
          // pass drained: advance or start unload
          bf_nxt   = '0;
          done_nxt = 1'b0;
          if (stg_r == LAST_STG) begin
            state_nxt = r2fft_pkg::ST_UNLOAD;
            ucnt_nxt  = '0;
          end else begin
            stg_nxt = stg_r + 3'd1;
          end
        end
      end
      r2fft_pkg::ST_UNLOAD: begin
        ra = ucnt_r;
        if (!pend_r && (!out_valid_r || out_tready)) begin
          uissue   = 1'b1;
          pend_nxt = 1'b1;
          ucnt_nxt = ucnt_r + AW'(1);
          if (ucnt_r == LAST_IDX) begin
            state_nxt = r2fft_pkg::ST_LOAD;
          end
        end
      end
      default: state_nxt = r2fft_pkg::ST_LOAD;
    endcase
  end

  // write port: load beats, then butterfly results (sum at a, difference at b)
  always_comb begin
    we = 1'b0;
    wa = lrev;
    wd = samp;
    if (state_r == r2fft_pkg::ST_LOAD) begin
      we = in_tvalid;
    end else if (v_r[4]) begin
      we = 1'b1;
      wa = ad4_r.a;
      wd = sum;
    end else if (v_r[5]) begin
      we = 1'b1;
      wa = ad4_r.b;
      wd = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= r2fft_pkg::ST_LOAD;
      lcnt_r      <= '0;
      stg_r       <= '0;
      bf_r        <= '0;
      ph_r        <= 1'b0;
      done_r      <= 1'b0;
      v_r         <= '0;
      ucnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcnt_r      <= lcnt_nxt;
      stg_r       <= stg_nxt;
      bf_r        <= bf_nxt;
      ph_r        <= ph_nxt;
      done_r      <= done_nxt;
      v_r         <= {v_r[4:1], issue};
      ucnt_r      <= ucnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: addresses follow their butterfly down the pipe
  always_ff @(posedge clk) begin
    if (issue) begin
      ad1_r <= cur_ad;
    end
    ad2_r <= ad1_r;
    ad3_r <= ad2_r;
    ad4_r <= ad3_r;
    if (v_r[1]) begin
      a_hold_r <= rd;
    end
    if (uissue) begin
      pend_last_r <= (ucnt_r == LAST_IDX);
    end
    if (pend_r) begin
      out_data_r <= rd;
      out_last_r <= pend_last_r;
    end
  end

  r2fft_ram #(
    .DEPTH(POINTS),
    .AW   (AW)
  ) u_ram (
    .clk(clk),
    .we (we),
    .wa (wa),
    .wd (wd),
    .ra (ra),
    .rd (rd)
  );

  r2fft_bfly u_bfly (
    .clk   (clk),
    .en_mul(v_r[2]),
    .en_add(v_r[3]),
    .a_in  (a_hold_r),
    .b_in  (rd),
    .tw    (r2fft_pkg::twiddle(ad2_r.k)),
    .sum_o (sum),
    .diff_o(diff)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.im, out_data_r.re};
  assign out_tlast  = out_last_r;

  `R2FFT_ASSERT_NOW(a_no_load_during_wb, in_tvalid && in_tready, !(v_r[4] || v_r[5]), "load beat during butterfly write")
  `R2FFT_ASSERT_NEXT(a_wb_pair, v_r[4], v_r[5], "butterfly write of a without b")
  `R2FFT_ASSERT_NEXT(a_read_lands, pend_r, out_valid_r, "unload read did not reach output")

endmodule

/* dv/tb_radix2_fft_frame.sv */
`timescale 1ns / 100ps

module tb_radix2_fft_frame;

  localparam int POINTS = 64;
  localparam int LOG2P = $clog2(POINTS);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               last;
  } bin_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] sample_re, [31:16] sample_im
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [23:0] bin_re, [47:24] bin_im
  logic        out_tlast;  // last_bin

  radix2_fft_frame #(.POINTS(POINTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sample_t pending_samples[$];
  bin_t    expected_bins[$];
  sample_t frame_buf[POINTS];
  int      frame_fill;

  int  mismatch_count;
  int  idle_cycles;
  bit  quiet_stretch;  // no random idling while set
  bit  hold_sender;    // pause the sender until every bin is out

  // Acceptance seen at the last rising edge, for the driver.
  logic    in_tready_seen;
  sample_t accepted;

  // Quarter cosine table, one entry per 1/64 turn, +1.0 held as 32767.
  localparam logic signed [15:0] round_cos_table[16] = '{
    16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
    16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
    16'sd12540, 16'sd9512, 16'sd6393, 16'sd3212};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Round half up after an exact Q1.15 product sum.
  function automatic logic signed [31:0] round_q15(input logic signed [47:0] v);
    logic signed [47:0] b;
    b = v + 48'sd16384;
    return 32'(b >>> 15);
  endfunction

  function automatic logic signed [23:0] clamp24(input logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sd8388607;
    if (v < -32'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [15:0] cos_q15(input int i);
    if (i >= 16) return 16'sd0;
    return round_cos_table[i];
  endfunction

  // Compute the bins of a full frame and queue them in natural order.
  task automatic predict_spectrum();
    logic signed [31:0] xr[POINTS];
    logic signed [31:0] xi[POINTS];
    logic signed [31:0] wr, wi, tr, ti;
    logic signed [31:0] c, s;
    int r, k, half, stride, a, b;
    bin_t bn;
    for (int i = 0; i < POINTS; i++) begin
      r = 0;
      for (int j = 0; j < LOG2P; j++) r |= ((i >> j) & 1) << (LOG2P - 1 - j);
      xr[r] = 32'(frame_buf[i].re);
      xi[r] = 32'(frame_buf[i].im);
    end
    for (int len = 2; len <= POINTS; len <<= 1) begin
      half = len >> 1;
      stride = 64 / len;
      for (int i = 0; i < POINTS; i += len) begin
        for (int j = 0; j < half; j++) begin
          k = (j * stride) & 31;
          if (k <= 16) begin
            c = 32'(cos_q15(k));
            s = 32'(cos_q15(16 - k));
          end else begin
            c = -32'(cos_q15(32 - k));
            s = 32'(cos_q15(k - 16));
          end
          wr = c;
          wi = -s;
          a = i + j;
          b = i + j + half;
          tr = round_q15(48'(xr[b]) * 48'(wr) - 48'(xi[b]) * 48'(wi));
          ti = round_q15(48'(xr[b]) * 48'(wi) + 48'(xi[b]) * 48'(wr));
          xr[b] = xr[a] - tr;
          xi[b] = xi[a] - ti;
          xr[a] = xr[a] + tr;
          xi[a] = xi[a] + ti;
        end
      end
    end
    for (int i = 0; i < POINTS; i++) begin
      bn.re = clamp24(xr[i]);
      bn.im = clamp24(xi[i]);
      bn.last = (i == POINTS - 1);
      expected_bins.push_back(bn);
    end
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 5))
      0: s.re = 16'sh7fff;
      1: s.re = 16'sh8000;
      default: s.re = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: s.im = 16'sh7fff;
      1: s.im = 16'sh8000;
      2: s.im = 16'sd0;  // real audio
      default: s.im = 16'($urandom);
    endcase
    return s;
  endfunction

  // Fill the queue: directed frames first, then random ones.
  initial begin
    sample_t s;
    // Impulse at sample zero, full-scale positive: flat spectrum.
    for (int i = 0; i < POINTS; i++) begin
      s.re = (i == 0) ? 16'sh7fff : 16'sd0;
      s.im = 16'sd0;
      pending_samples.push_back(s);
    end
    // Constant full-scale negative in both parts: all energy in bin zero.
    for (int i = 0; i < POINTS; i++) begin
      s.re = 16'sh8000;
      s.im = 16'sh8000;
      pending_samples.push_back(s);
    end
    // Alternating extremes: energy at the Nyquist bin.
    for (int i = 0; i < POINTS; i++) begin
      s.re = i[0] ? 16'sh8000 : 16'sh7fff;
      s.im = i[0] ? 16'sh7fff : 16'sh8000;
      pending_samples.push_back(s);
    end
    // Random frames.
    for (int i = 0; i < 2 * POINTS; i++) pending_samples.push_back(random_sample());
  end

  // Driver: present the head of the queue, change on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready_seen) begin
      if (pending_samples.size() != 0 && !hold_sender &&
          (quiet_stretch || $urandom_range(0, 99) >= 8)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_samples.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_tready_seen <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      accepted = in_tdata;
      frame_buf[frame_fill] = accepted;
      frame_fill++;
      if (frame_fill == POINTS) begin
        frame_fill = 0;
        predict_spectrum();
      end
    end
  end

  // Receiver stall, also changed on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= quiet_stretch || ($urandom_range(0, 99) >= 8);
  end

  // Monitor: compare each accepted bin with the oldest expectation.
  always @(posedge clk) begin
    bin_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bins.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected bin: re=%0d im=%0d last=%0b",
                   $signed(out_tdata[23:0]), $signed(out_tdata[47:24]), out_tlast);
      end else begin
        want = expected_bins.pop_front();
        if (out_tdata[23:0] !== want.re || out_tdata[47:24] !== want.im ||
            out_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("bin mismatch: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                     want.re, want.im, want.last, $signed(out_tdata[23:0]),
                     $signed(out_tdata[47:24]), out_tlast);
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sequence the run: reset, idling phases, sender pause, drain, verdict.
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    in_tready_seen = 1'b0;
    frame_fill = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    quiet_stretch = 1'b0;
    hold_sender = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // Hold the sender once after the directed frames until all bins arrive;
    // set at once so no random sample slips out behind the last directed one.
    wait (pending_samples.size() <= 2 * POINTS);
    hold_sender = 1'b1;
    wait (expected_bins.size() == 0 && frame_fill == 0);
    repeat (10) @(posedge clk);
    @(negedge clk) begin
      hold_sender <= 1'b0;
      quiet_stretch <= 1'b1;
    end
    // Long stretch without idling over one random frame.
    wait (pending_samples.size() <= POINTS);
    @(negedge clk) quiet_stretch <= 1'b0;
    wait (pending_samples.size() == 0 && !in_tvalid);
    wait (expected_bins.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_bins.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
